// File: sv/efp_pkg.sv
// Shared types and constants of the parabolic extremum finder.
// Used by every module of the block; depends on nothing else.

package efp_pkg;

   // Width of the sample period register and of the refinement quotient.
   localparam int PERIOD_BITS = 12;
   // Bits of the divider step counter (counts PERIOD_BITS - 1 down to 0).
   localparam int COUNT_BITS = 4;
   // Sample period after reset: five minutes.
   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 12'd300;

   // Configuration port geometry: two registers at byte addresses 0 and 8.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam logic REG_QUERY_TIME = 1'b0;
   localparam logic REG_SAMPLE_PERIOD = 1'b1;

   // Extremum kinds.
   localparam logic KIND_LOW = 1'b0;
   localparam logic KIND_HIGH = 1'b1;

   // Role of one result in the four-result report.
   typedef enum logic [1:0] {
      ROLE_PREVIOUS  = 2'd0,
      ROLE_NEXT_LOW  = 2'd1,
      ROLE_NEXT_HIGH = 2'd2,
      ROLE_SUMMARY   = 2'd3
   } role_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_MULT,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_UPDATE,
      ST_EMIT_PREV,
      ST_EMIT_LOW,
      ST_EMIT_HIGH,
      ST_EMIT_SUM
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     accept;
      logic     classify;
      logic     mult;
      logic     div_load;
      logic     div_step;
      logic     update;
      logic     run_clear;
      role_type role;
   } efp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic extremum;
      logic div_bypass;
      logic div_done;
      logic last;
   } efp_status_type;

endpackage

// File: sv/efp_regs.sv
// Configuration registers of the parabolic extremum finder behind an APB-style port.
// Depends on efp_pkg for the address map and reset values.

module efp_regs
   import efp_pkg::*;
#(
   parameter int TIME_BITS = 40
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output logic [TIME_BITS-1:0]     query_time,
   output logic [PERIOD_BITS-1:0]   sample_period
);

   logic [TIME_BITS-1:0]   query_ff, query_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic                   write_en;
   logic                   reg_sel;

   // Registers sit on 8-byte boundaries; bit 3 picks one of them.
   assign reg_sel  = paddr[3];
   assign write_en = psel && penable && pwrite;
   assign pready   = 1'b1;

   // Next values of the two registers.
   always_comb begin
      query_in  = query_ff;
      period_in = period_ff;
      if (write_en) begin
         unique case (reg_sel)
            REG_QUERY_TIME:    query_in  = pwdata[TIME_BITS-1:0];
            REG_SAMPLE_PERIOD: period_in = pwdata[PERIOD_BITS-1:0];
            default:           query_in  = query_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_ff  <= '0;
         period_ff <= PERIOD_RESET;
      end else begin
         query_ff  <= query_in;
         period_ff <= period_in;
      end
   end

   // Read-back of the selected register.
   always_comb begin
      unique case (reg_sel)
         REG_QUERY_TIME:    prdata = CSR_DATA_BITS'(query_ff);
         REG_SAMPLE_PERIOD: prdata = CSR_DATA_BITS'(period_ff);
         default:           prdata = '0;
      endcase
   end

   assign query_time    = query_ff;
   assign sample_period = period_ff;

endmodule

// File: sv/efp_ctrl.sv
// Controller state machine of the parabolic extremum finder.
// Depends on efp_pkg for the state, command and status types.

module efp_ctrl
   import efp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  efp_status_type status,
   output efp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CLASSIFY;
         ST_CLASSIFY:  state_in = status.extremum ? ST_MULT : ST_UPDATE;
         ST_MULT:      state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = status.div_bypass ? ST_UPDATE : ST_DIVIDE;
         ST_DIVIDE:    if (status.div_done) state_in = ST_UPDATE;
         ST_UPDATE:    state_in = status.last ? ST_EMIT_PREV : ST_IDLE;
         ST_EMIT_PREV: if (!rsp_stall) state_in = ST_EMIT_LOW;
         ST_EMIT_LOW:  if (!rsp_stall) state_in = ST_EMIT_HIGH;
         ST_EMIT_HIGH: if (!rsp_stall) state_in = ST_EMIT_SUM;
         ST_EMIT_SUM:  if (!rsp_stall) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd       = '0;
      cmd.role  = ROLE_PREVIOUS;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_CLASSIFY: cmd.classify = 1'b1;
         ST_MULT:     cmd.mult     = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIVIDE:   cmd.div_step = 1'b1;
         ST_UPDATE:   cmd.update   = 1'b1;
         ST_EMIT_PREV: begin
            rsp_valid = 1'b1;
            cmd.role  = ROLE_PREVIOUS;
         end
         ST_EMIT_LOW: begin
            rsp_valid = 1'b1;
            cmd.role  = ROLE_NEXT_LOW;
         end
         ST_EMIT_HIGH: begin
            rsp_valid = 1'b1;
            cmd.role  = ROLE_NEXT_HIGH;
         end
         ST_EMIT_SUM: begin
            rsp_valid     = 1'b1;
            cmd.role      = ROLE_SUMMARY;
            cmd.run_clear = !rsp_stall;
         end
         default: req_stall = 1'b1;
      endcase
   end

`ifndef SYNTH
   // A request is never taken while a result is on offer.
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && !req_stall))
      else $error("request taken while a result is pending");

   // A taken request always starts classification of the window.
   assert property (@(posedge clock) disable iff (reset)
      (!req_stall && req_valid) |=> (state_ff == ST_CLASSIFY))
      else $error("accepted request did not start processing");

   // Once the summary is taken the block returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_SUM && !rsp_stall) |=> (state_ff == ST_IDLE && !rsp_valid))
      else $error("block did not return to idle after the summary");
`endif

endmodule

// File: sv/efp_dp.sv
// Datapath of the parabolic extremum finder: sample window, refinement divider,
// extremum slots and result formatting. Depends on efp_pkg.

module efp_dp
   import efp_pkg::*;
#(
   parameter int HEIGHT_BITS = 20,
   parameter int TIME_BITS   = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  efp_cmd_type                   cmd,
   output efp_status_type                status,
   input  logic [TIME_BITS-1:0]          query_time,
   input  logic [PERIOD_BITS-1:0]        sample_period,
   input  logic [TIME_BITS-1:0]          req_sample_time,
   input  logic signed [HEIGHT_BITS-1:0] req_sample_height,
   input  logic                          req_last_sample,
   output logic [1:0]                    rsp_role,
   output logic                          rsp_extremum_kind,
   output logic [TIME_BITS-1:0]          rsp_extremum_time,
   output logic                          rsp_extremum_valid,
   output logic signed [HEIGHT_BITS-1:0] rsp_current_height,
   output logic                          rsp_rising,
   output logic                          rsp_all_valid,
   output logic                          rsp_last_result
);

   localparam int DIFF_W = HEIGHT_BITS + 1;
   localparam int CURV_W = HEIGHT_BITS + 2;
   localparam int AD_W   = HEIGHT_BITS + 3;
   localparam int AN_W   = PERIOD_BITS + HEIGHT_BITS + 1;
   localparam int REM_W  = AN_W + 1;
   localparam int DSH_W  = AD_W + PERIOD_BITS;

   // Incoming sample held during processing.
   logic [TIME_BITS-1:0]          new_t_ff;
   logic signed [HEIGHT_BITS-1:0] new_h_ff;
   logic                          last_ff;

   // Run state.
   logic signed [HEIGHT_BITS-1:0] older_h_ff, older_h_in;
   logic signed [HEIGHT_BITS-1:0] middle_h_ff, middle_h_in;
   logic [TIME_BITS-1:0]          middle_t_ff, middle_t_in;
   logic [1:0]                    fill_ff, fill_in;
   logic                          before_kind_ff, before_kind_in;
   logic [TIME_BITS-1:0]          before_time_ff, before_time_in;
   logic                          before_found_ff, before_found_in;
   logic [TIME_BITS-1:0]          low_time_ff, low_time_in;
   logic                          low_found_ff, low_found_in;
   logic [TIME_BITS-1:0]          high_time_ff, high_time_in;
   logic                          high_found_ff, high_found_in;
   logic signed [HEIGHT_BITS-1:0] early_h_ff, early_h_in;
   logic signed [HEIGHT_BITS-1:0] late_h_ff, late_h_in;
   logic signed [HEIGHT_BITS-1:0] query_h_ff, query_h_in;

   // Refinement working registers.
   logic                    ext_ff, kind_ff, neg_ff, curv_zero_ff, clamp_ff;
   logic [DIFF_W-1:0]       abs_diff_ff;
   logic [AD_W-1:0]         ad_ff;
   logic [AN_W-1:0]         an_ff;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [DSH_W-1:0]        dsh_ff, dsh_in;
   logic [PERIOD_BITS-1:0]  q_ff, q_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;

   // Window classification signals.
   logic signed [CURV_W-1:0] p_c, m_c, n_c, curv;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        abs_diff;
   logic [CURV_W-1:0]        abs_curv;
   logic                     is_low, is_high, window_full, is_ext;

   logic [TIME_BITS-1:0] query_minus, query_plus, refined_time;
   logic                 div_ge, query_nonzero;
   logic                 prev_ok, low_ok, high_ok;

   // Classify the middle sample against its neighbours.
   always_comb begin
      p_c         = CURV_W'(older_h_ff);
      m_c         = CURV_W'(middle_h_ff);
      n_c         = CURV_W'(new_h_ff);
      curv        = p_c - (m_c <<< 1) + n_c;
      diff        = DIFF_W'(older_h_ff) - DIFF_W'(new_h_ff);
      abs_diff    = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      abs_curv    = curv[CURV_W-1] ? CURV_W'(-curv) : CURV_W'(curv);
      is_low      = (middle_h_ff <= older_h_ff) && (middle_h_ff < new_h_ff);
      is_high     = (middle_h_ff >= older_h_ff) && (middle_h_ff > new_h_ff);
      window_full = fill_ff[1];
      is_ext      = window_full && (is_low || is_high);
   end

   // Query-time neighbours, wrapping in the time width.
   assign query_minus = query_time - TIME_BITS'(sample_period);
   assign query_plus  = query_time + TIME_BITS'(sample_period);

   // Refined time of the middle sample.
   assign refined_time = neg_ff ? (middle_t_ff - TIME_BITS'(q_ff))
                                : (middle_t_ff + TIME_BITS'(q_ff));

   // Restoring divider step: one quotient bit a cycle.
   assign div_ge = (DSH_W'(rem_ff) >= dsh_ff);

   // Sample capture.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         new_t_ff <= req_sample_time;
         new_h_ff <= req_sample_height;
         last_ff  <= req_last_sample;
      end
   end

   // Classification and multiplication registers.
   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         ext_ff       <= is_ext;
         kind_ff      <= is_low ? KIND_LOW : KIND_HIGH;
         neg_ff       <= diff[DIFF_W-1] != curv[CURV_W-1];
         curv_zero_ff <= (curv == '0);
         abs_diff_ff  <= abs_diff;
         ad_ff        <= {abs_curv, 1'b0};
      end
      if (cmd.mult) begin
         an_ff    <= AN_W'(sample_period) * AN_W'(abs_diff_ff);
         clamp_ff <= (sample_period == '0) || (AD_W'(abs_diff_ff) >= ad_ff);
      end
   end

   // Divider next values.
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (cmd.div_load) begin
         cnt_in = COUNT_BITS'(PERIOD_BITS - 1);
         rem_in = REM_W'({an_ff, 1'b0}) + REM_W'(ad_ff);
         dsh_in = DSH_W'(ad_ff) << PERIOD_BITS;
         priority if (curv_zero_ff) begin
            q_in = '0;
         end else if (clamp_ff) begin
            q_in = sample_period;
         end else begin
            q_in = '0;
         end
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = REM_W'(DSH_W'(rem_ff) - dsh_ff);
         end
         q_in   = {q_ff[PERIOD_BITS-2:0], div_ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   // Run state next values.
   always_comb begin
      older_h_in      = older_h_ff;
      middle_h_in     = middle_h_ff;
      middle_t_in     = middle_t_ff;
      fill_in         = fill_ff;
      before_kind_in  = before_kind_ff;
      before_time_in  = before_time_ff;
      before_found_in = before_found_ff;
      low_time_in     = low_time_ff;
      low_found_in    = low_found_ff;
      high_time_in    = high_time_ff;
      high_found_in   = high_found_ff;
      early_h_in      = early_h_ff;
      late_h_in       = late_h_ff;
      query_h_in      = query_h_ff;

      if (cmd.run_clear) begin
         older_h_in      = '0;
         middle_h_in     = '0;
         middle_t_in     = '0;
         fill_in         = '0;
         before_kind_in  = KIND_LOW;
         before_time_in  = '0;
         before_found_in = 1'b0;
         low_time_in     = '0;
         low_found_in    = 1'b0;
         high_time_in    = '0;
         high_found_in   = 1'b0;
         early_h_in      = '0;
         late_h_in       = '0;
         query_h_in      = '0;
      end

      // Heights seen at the query time and one period either side.
      if (cmd.accept) begin
         if (req_sample_time == query_time) query_h_in = req_sample_height;
         if (req_sample_time == query_minus) early_h_in = req_sample_height;
         if (req_sample_time == query_plus) late_h_in = req_sample_height;
      end

      // File the refined extremum and slide the window.
      if (cmd.update) begin
         if (ext_ff) begin
            priority if (refined_time <= query_time) begin
               if (!before_found_ff || (refined_time > before_time_ff)) begin
                  before_found_in = 1'b1;
                  before_time_in  = refined_time;
                  before_kind_in  = kind_ff;
               end
            end else if (kind_ff == KIND_LOW && !low_found_ff) begin
               low_found_in = 1'b1;
               low_time_in  = refined_time;
            end else if (kind_ff == KIND_HIGH && !high_found_ff) begin
               high_found_in = 1'b1;
               high_time_in  = refined_time;
            end else begin
               low_found_in = low_found_ff;
            end
         end
         older_h_in  = middle_h_ff;
         middle_h_in = new_h_ff;
         middle_t_in = new_t_ff;
         if (!fill_ff[1]) fill_in = fill_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_h_ff      <= '0;
         middle_h_ff     <= '0;
         middle_t_ff     <= '0;
         fill_ff         <= '0;
         before_kind_ff  <= KIND_LOW;
         before_time_ff  <= '0;
         before_found_ff <= 1'b0;
         low_time_ff     <= '0;
         low_found_ff    <= 1'b0;
         high_time_ff    <= '0;
         high_found_ff   <= 1'b0;
         early_h_ff      <= '0;
         late_h_ff       <= '0;
         query_h_ff      <= '0;
      end else begin
         older_h_ff      <= older_h_in;
         middle_h_ff     <= middle_h_in;
         middle_t_ff     <= middle_t_in;
         fill_ff         <= fill_in;
         before_kind_ff  <= before_kind_in;
         before_time_ff  <= before_time_in;
         before_found_ff <= before_found_in;
         low_time_ff     <= low_time_in;
         low_found_ff    <= low_found_in;
         high_time_ff    <= high_time_in;
         high_found_ff   <= high_found_in;
         early_h_ff      <= early_h_in;
         late_h_ff       <= late_h_in;
         query_h_ff      <= query_h_in;
      end
   end

   // Status towards the controller.
   always_comb begin
      status.extremum   = is_ext;
      status.div_bypass = curv_zero_ff || clamp_ff;
      status.div_done   = (cnt_ff == '0);
      status.last       = last_ff;
   end

   // Result formatting from the stored slots.
   assign query_nonzero = (query_time != '0);
   assign prev_ok       = query_nonzero && before_found_ff;
   assign low_ok        = query_nonzero && low_found_ff;
   assign high_ok       = query_nonzero && high_found_ff;

   always_comb begin
      rsp_role           = cmd.role;
      rsp_extremum_kind  = KIND_LOW;
      rsp_extremum_time  = '0;
      rsp_extremum_valid = 1'b0;
      rsp_current_height = '0;
      rsp_rising         = 1'b0;
      rsp_all_valid      = 1'b0;
      rsp_last_result    = 1'b0;
      unique case (cmd.role)
         ROLE_PREVIOUS: begin
            rsp_extremum_kind  = prev_ok ? before_kind_ff : KIND_LOW;
            rsp_extremum_time  = prev_ok ? before_time_ff : '0;
            rsp_extremum_valid = prev_ok;
         end
         ROLE_NEXT_LOW: begin
            rsp_extremum_kind  = KIND_LOW;
            rsp_extremum_time  = low_ok ? low_time_ff : '0;
            rsp_extremum_valid = low_ok;
         end
         ROLE_NEXT_HIGH: begin
            rsp_extremum_kind  = KIND_HIGH;
            rsp_extremum_time  = high_ok ? high_time_ff : '0;
            rsp_extremum_valid = high_ok;
         end
         ROLE_SUMMARY: begin
            rsp_current_height = query_nonzero ? query_h_ff : '0;
            rsp_rising         = query_nonzero && (late_h_ff > early_h_ff);
            rsp_all_valid      = prev_ok && low_ok && high_ok;
            rsp_last_result    = 1'b1;
         end
         default: rsp_last_result = 1'b0;
      endcase
   end

`ifndef SYNTH
   // The refinement offset never exceeds one sample period.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.update && ext_ff) |-> (q_ff <= sample_period))
      else $error("refinement offset exceeds one period");

   // Clearing the run empties the window and every slot.
   assert property (@(posedge clock) disable iff (reset)
      cmd.run_clear |=> (fill_ff == '0 && !before_found_ff && !low_found_ff && !high_found_ff))
      else $error("run state not cleared after the summary");
`endif

endmodule

// File: sv/extremum_finder_parabolic.sv
// Top level of the parabolic extremum finder.
// Instantiates efp_regs, efp_ctrl and efp_dp; depends on efp_pkg.
//
// Usage: height samples arrive one request at a time on the req_ channel
// (valid/stall). Each request slides a three-sample window; when the middle
// sample is a low or a high its time is refined by the parabola vertex and
// filed as the previous extremum (at or before query_time) or as the first
// next low or next high. The request marked last_sample is followed by four
// results on the rsp_ channel: previous, next low, next high and a summary.
// A request is classified, then updates the window; one refining an extremum
// also passes through the multiplication, divider load and 12-step restoring
// divider, skipped if the offset is clamped or zero. No request is taken before
// the last is through; the first result is offered once the last request has
// updated the window. The four results follow one per cycle when the receiver
// does not stall; while rsp_stall is high the current result is held and no
// request is taken. The query time and sample period are to be written through
// the APB-style port only while idle, which the block does not enforce. Reset
// clears the run state, sets query_time to 0 and sample_period to 300 seconds.

module extremum_finder_parabolic
   import efp_pkg::*;
#(
   parameter int HEIGHT_BITS = 20,
   parameter int TIME_BITS   = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [TIME_BITS-1:0]          req_sample_time,
   input  logic signed [HEIGHT_BITS-1:0] req_sample_height,
   input  logic                          req_last_sample,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_role,
   output logic                          rsp_extremum_kind,
   output logic [TIME_BITS-1:0]          rsp_extremum_time,
   output logic                          rsp_extremum_valid,
   output logic signed [HEIGHT_BITS-1:0] rsp_current_height,
   output logic                          rsp_rising,
   output logic                          rsp_all_valid,
   output logic                          rsp_last_result,
   // Configuration port.
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   logic [TIME_BITS-1:0]   query_time;
   logic [PERIOD_BITS-1:0] sample_period;
   efp_cmd_type            cmd;
   efp_status_type         status;

   // Configuration registers.
   efp_regs #(
      .TIME_BITS(TIME_BITS)
   ) u_regs (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .query_time    (query_time),
      .sample_period (sample_period)
   );

   // Sequencing of one request and of the result report.
   efp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Window, refinement and slots.
   efp_dp #(
      .HEIGHT_BITS(HEIGHT_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .query_time         (query_time),
      .sample_period      (sample_period),
      .req_sample_time    (req_sample_time),
      .req_sample_height  (req_sample_height),
      .req_last_sample    (req_last_sample),
      .rsp_role           (rsp_role),
      .rsp_extremum_kind  (rsp_extremum_kind),
      .rsp_extremum_time  (rsp_extremum_time),
      .rsp_extremum_valid (rsp_extremum_valid),
      .rsp_current_height (rsp_current_height),
      .rsp_rising         (rsp_rising),
      .rsp_all_valid      (rsp_all_valid),
      .rsp_last_result    (rsp_last_result)
   );

endmodule

// File: verif/extremum_finder_parabolic_tb.sv
`timescale 1ns / 100ps

// Self-checking testbench of extremum_finder_parabolic: queued height-sample requests,
// a predictor of the four-result extremum report and a field-by-field result checker.
// Depends on efp_pkg and the RTL of the block only.

module extremum_finder_parabolic_tb
   import efp_pkg::*;
();

   localparam int HEIGHT_W = 20;
   localparam int TIME_W = 40;
   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_LIMIT = 50;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;
   localparam int HEIGHT_MAX = 524287;
   localparam int HEIGHT_MIN = -524288;

   // One height sample as it travels on the request channel.
   typedef struct {
      logic [TIME_W-1:0]          stime;
      logic signed [HEIGHT_W-1:0] height;
      logic                       last;
   } tide_sample_type;

   // One result of the extremum report.
   typedef struct {
      role_type                   role;
      logic                       kind;
      logic [TIME_W-1:0]          etime;
      logic                       evalid;
      logic signed [HEIGHT_W-1:0] height;
      logic                       rising;
      logic                       allv;
      logic                       last;
   } tide_report_type;

   typedef enum int {STYLE_WALK, STYLE_FLAT, STYLE_NOISE, STYLE_SWING} run_style_type;
   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   // Block ports; every input starts at a known value.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [TIME_W-1:0]             req_sample_time = '0;
   logic signed [HEIGHT_W-1:0]    req_sample_height = '0;
   logic                          req_last_sample = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_role;
   logic                          rsp_extremum_kind;
   logic [TIME_W-1:0]             rsp_extremum_time;
   logic                          rsp_extremum_valid;
   logic signed [HEIGHT_W-1:0]    rsp_current_height;
   logic                          rsp_rising;
   logic                          rsp_all_valid;
   logic                          rsp_last_result;
   logic                          psel = 1'b0;
   logic                          penable = 1'b0;
   logic                          pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]      paddr = '0;
   logic [CSR_DATA_BITS-1:0]      pwdata = '0;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   // Request queue and handshake bookkeeping.
   tide_sample_type samples_todo[$];
   tide_report_type extrema_due[$];
   int              items_queued = 0;
   int              items_taken = 0;
   logic            req_taken = 1'b0;
   int              burst_left = 0;
   int              gap_left = 0;
   int              holds_asked = 0;
   int              holds_served = 0;
   int              hold_left = 0;
   stall_mode_type  stall_mode = STALL_NONE;
   int              mode_left = 0;
   int              idle_cycles = 0;
   int              reports_seen = 0;
   int              mismatches = 0;

   // Predictor copy of the registers and of the run state.
   logic [TIME_W-1:0]      cfg_query = '0;
   logic [PERIOD_BITS-1:0] cfg_period = PERIOD_RESET;
   longint                 win_old_h = 0;
   longint                 win_mid_h = 0;
   logic [TIME_W-1:0]      win_mid_t = '0;
   int                     win_fill = 0;
   logic                   prev_kind = KIND_LOW;
   logic [TIME_W-1:0]      prev_t = '0;
   bit                     prev_found = 0;
   logic [TIME_W-1:0]      low_t = '0;
   bit                     low_found = 0;
   logic [TIME_W-1:0]      high_t = '0;
   bit                     high_found = 0;
   longint                 h_early = 0;
   longint                 h_late = 0;
   longint                 h_query = 0;

   extremum_finder_parabolic #(
      .HEIGHT_BITS(HEIGHT_W),
      .TIME_BITS(TIME_W)
   ) uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Parabola vertex time of the middle sample, clamped to one period, rounded
   // half away from zero.
   function automatic logic [TIME_W-1:0] vertex_time(logic [TIME_W-1:0] mid_t, longint p,
                                                     longint m, longint n);
      longint          curv;
      longint          diff;
      longint unsigned per;
      longint unsigned num;
      longint unsigned den;
      longint unsigned shift;
      bit              neg;
      curv = p - 2 * m + n;
      diff = p - n;
      if (curv == 0) return mid_t;
      per = longint'(cfg_period);
      neg = (diff < 0) != (curv < 0);
      num = per * longint'((diff < 0) ? -diff : diff);
      den = 2 * longint'((curv < 0) ? -curv : curv);
      if (num >= per * den) shift = per;
      else shift = (2 * num + den) / (2 * den);
      return neg ? mid_t - shift[TIME_W-1:0] : mid_t + shift[TIME_W-1:0];
   endfunction

   function automatic tide_report_type make_report(role_type role, logic kind,
                                                   logic [TIME_W-1:0] etime, logic evalid,
                                                   longint height, logic rising, logic allv,
                                                   logic last);
      tide_report_type r;
      r.role = role;
      r.kind = kind;
      r.etime = etime;
      r.evalid = evalid;
      r.height = HEIGHT_W'(height);
      r.rising = rising;
      r.allv = allv;
      r.last = last;
      return r;
   endfunction

   // Advance the predicted run state by one accepted sample; the last sample of a
   // run queues the four expected results and clears the run.
   task automatic fold_sample(input tide_sample_type s);
      longint            h;
      logic [TIME_W-1:0] rt;
      bit                is_low;
      bit                is_high;
      bit                qv;
      bit                pv;
      bit                lv;
      bit                hv;
      h = longint'(s.height);
      if (s.stime == cfg_query) h_query = h;
      if (s.stime == TIME_W'(cfg_query - cfg_period)) h_early = h;
      if (s.stime == TIME_W'(cfg_query + cfg_period)) h_late = h;

      if (win_fill >= 2) begin
         is_low = win_mid_h <= win_old_h && win_mid_h < h;
         is_high = !is_low && win_mid_h >= win_old_h && win_mid_h > h;
         if (is_low || is_high) begin
            rt = vertex_time(win_mid_t, win_old_h, win_mid_h, h);
            if (rt <= cfg_query) begin
               if (!prev_found || rt > prev_t) begin
                  prev_found = 1;
                  prev_t = rt;
                  prev_kind = is_high ? KIND_HIGH : KIND_LOW;
               end
            end else if (is_low && !low_found) begin
               low_found = 1;
               low_t = rt;
            end else if (is_high && !high_found) begin
               high_found = 1;
               high_t = rt;
            end
         end
      end
      win_old_h = win_mid_h;
      win_mid_h = h;
      win_mid_t = s.stime;
      if (win_fill < 2) win_fill++;

      if (s.last) begin
         qv = cfg_query != 0;
         pv = qv && prev_found;
         lv = qv && low_found;
         hv = qv && high_found;
         extrema_due.push_back(make_report(ROLE_PREVIOUS, pv ? prev_kind : KIND_LOW,
                                           pv ? prev_t : '0, pv, 0, 0, 0, 0));
         extrema_due.push_back(make_report(ROLE_NEXT_LOW, KIND_LOW, lv ? low_t : '0, lv,
                                           0, 0, 0, 0));
         extrema_due.push_back(make_report(ROLE_NEXT_HIGH, KIND_HIGH, hv ? high_t : '0, hv,
                                           0, 0, 0, 0));
         extrema_due.push_back(make_report(ROLE_SUMMARY, KIND_LOW, '0, 0, qv ? h_query : 0,
                                           qv && (h_late > h_early), pv && lv && hv, 1));
         win_old_h = 0;
         win_mid_h = 0;
         win_mid_t = '0;
         win_fill = 0;
         prev_kind = KIND_LOW;
         prev_t = '0;
         prev_found = 0;
         low_t = '0;
         low_found = 0;
         high_t = '0;
         high_found = 0;
         h_early = 0;
         h_late = 0;
         h_query = 0;
      end
   endtask

   task automatic flag_mismatch(input string field, input logic [63:0] got,
                                input logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: result %0d %s mismatch: got %0h, expected %0h",
                  $time, reports_seen, field, got, want);
   endtask

   // Sample the request and result channels at the rising edge, predict, check
   // and keep the watchdog on progress.
   always @(posedge clock) begin : result_check
      tide_sample_type got_s;
      tide_report_type want;
      req_taken <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            got_s.stime = req_sample_time;
            got_s.height = req_sample_height;
            got_s.last = req_last_sample;
            fold_sample(got_s);
            items_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (extrema_due.size() == 0) begin
               flag_mismatch("unexpected result", rsp_role, 0);
            end else begin
               want = extrema_due.pop_front();
               if (rsp_role !== want.role) flag_mismatch("role", rsp_role, want.role);
               if (rsp_extremum_kind !== want.kind)
                  flag_mismatch("extremum_kind", rsp_extremum_kind, want.kind);
               if (rsp_extremum_time !== want.etime)
                  flag_mismatch("extremum_time", rsp_extremum_time, want.etime);
               if (rsp_extremum_valid !== want.evalid)
                  flag_mismatch("extremum_valid", rsp_extremum_valid, want.evalid);
               if (rsp_current_height !== want.height)
                  flag_mismatch("current_height", rsp_current_height, want.height);
               if (rsp_rising !== want.rising) flag_mismatch("rising", rsp_rising, want.rising);
               if (rsp_all_valid !== want.allv)
                  flag_mismatch("all_valid", rsp_all_valid, want.allv);
               if (rsp_last_result !== want.last)
                  flag_mismatch("last_result", rsp_last_result, want.last);
            end
            reports_seen++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("extremum_finder_parabolic_tb: FAIL");
            $finish;
         end
      end
   end

   // Request driver: bursts of random length separated by random gaps. A stalled
   // request is held unchanged until it is taken.
   always @(negedge clock) begin : sample_driver
      tide_sample_type s;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // Stalled: hold the payload.
      end else if (gap_left > 0) begin
         gap_left--;
         req_valid <= 1'b0;
      end else if (samples_todo.size() > 0) begin
         s = samples_todo.pop_front();
         req_sample_time <= s.stime;
         req_sample_height <= s.height;
         req_last_sample <= s.last;
         req_valid <= 1'b1;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result stall: random modes of random length, and long hold-offs on demand.
   always @(negedge clock) begin : result_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE: rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 4) < 3);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   function automatic void push_sample(logic [TIME_W-1:0] t, int h, logic last);
      tide_sample_type s;
      s.stime = t;
      s.height = HEIGHT_W'(h);
      s.last = last;
      samples_todo.push_back(s);
      items_queued++;
   endfunction

   // Queue one run of samples around the query time (noise runs at random times); returns its length.
   function automatic int queue_run();
      int                pick;
      int                len;
      int                step;
      int                walk;
      int                dir;
      int                h;
      logic [TIME_W-1:0] t;
      run_style_type     style;
      pick = $urandom_range(0, 19);
      if (pick < 13) style = STYLE_WALK;
      else if (pick < 16) style = STYLE_FLAT;
      else if (pick < 19) style = STYLE_NOISE;
      else style = STYLE_SWING;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      step = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : int'(cfg_period);
      t = cfg_query - TIME_W'(step * $urandom_range(0, len));
      walk = int'($urandom_range(0, 800000)) - 400000;
      dir = 1;
      for (int k = 0; k < len; k++) begin
         case (style)
            STYLE_FLAT: h = int'($urandom_range(0, 4)) - 2;
            STYLE_NOISE: begin
               h = int'($urandom_range(0, 1048575)) + HEIGHT_MIN;
               t = TIME_W'({$urandom, $urandom});
            end
            STYLE_SWING: h = $urandom_range(0, 1) ? HEIGHT_MAX : HEIGHT_MIN;
            default: begin
               walk += dir * int'($urandom_range(1, 30000));
               if (walk > HEIGHT_MAX) walk = HEIGHT_MAX;
               if (walk < HEIGHT_MIN) walk = HEIGHT_MIN;
               if ($urandom_range(0, 3) == 0) dir = -dir;
               h = walk;
            end
         endcase
         // Noise runs may end without the last flag, leaving the run open.
         push_sample(t, h, k == len - 1 && (style != STYLE_NOISE || $urandom_range(0, 1)));
         t += TIME_W'(step);
      end
      return len;
   endfunction

   task automatic wait_idle();
      while (items_taken != items_queued || extrema_due.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Write both registers once the block has drained and settled.
   task automatic configure(input logic [TIME_W-1:0] query,
                            input logic [PERIOD_BITS-1:0] period);
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write({REG_QUERY_TIME, 3'b000}, CSR_DATA_BITS'(query));
      csr_write({REG_SAMPLE_PERIOD, 3'b000}, CSR_DATA_BITS'(period));
      cfg_query = query;
      cfg_period = period;
   endtask

   initial begin : stimulus
      int                     n;
      logic [TIME_W-1:0]      q;
      logic [PERIOD_BITS-1:0] p;
      logic [TIME_W-1:0]      t0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Query time zero after reset: every field but role, last and the next-high kind is zero.
      push_sample(0, 0, 0);
      push_sample(300, HEIGHT_MIN, 0);
      push_sample(600, HEIGHT_MAX, 1);

      // A low before the query, a high at it refined to just after it, a next low and a second high.
      configure(3000, 300);
      push_sample(2100, 0, 0);
      push_sample(2400, -100, 0);
      push_sample(2700, 50, 0);
      push_sample(3000, 200, 0);
      push_sample(3300, 150, 0);
      push_sample(3600, HEIGHT_MIN, 0);
      push_sample(3900, HEIGHT_MAX, 0);
      push_sample(4200, 0, 1);
      // No sample at the query time or a period either side of it.
      push_sample(1, 7, 0);
      push_sample(2, -7, 0);
      push_sample(3, 7, 1);
      // A run too short to fill the window.
      push_sample(3000, 99, 0);
      push_sample(3300, -5, 1);

      // Query near the top of the time range: sample and refined times wrap.
      configure(TIME_MAX - 1000, 3600);
      t0 = TIME_MAX - 4600;
      push_sample(t0, 0, 0);
      push_sample(t0 + 3600, 1000, 0);
      push_sample(t0 + 7200, 999, 0);
      push_sample(t0 + 10800, -5000, 0);
      push_sample(t0 + 14400, 2000, 0);
      push_sample(t0 + 18000, 10, 1);

      // Zero period: no refinement offset.
      configure(5000, 0);
      push_sample(5000, 10, 0);
      push_sample(5000, -3, 0);
      push_sample(5000, 8, 0);
      push_sample(5000, 1, 1);

      // Random phases over several register settings, the extremes among them.
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin q = TIME_W'({$urandom, $urandom}); p = PERIOD_BITS'(300); end
            1: begin q = TIME_MAX; p = PERIOD_BITS'(3600); end
            2: begin q = TIME_W'(1); p = PERIOD_BITS'(1); end
            3: begin q = TIME_W'({$urandom, $urandom}); p = '1; end
            4: begin q = '0; p = PERIOD_BITS'($urandom_range(1, 3600)); end
            5: begin
               q = TIME_W'({$urandom, $urandom});
               p = PERIOD_BITS'($urandom_range(1, 3600));
            end
            default: begin q = TIME_W'({$urandom, $urandom}); p = PERIOD_BITS'($urandom); end
         endcase
         configure(q, p);
         n = 0;
         while (n < 8) n += queue_run();
         // A long result hold-off while requests keep coming, so the block backs up.
         if (phase == 1) begin
            holds_asked++;
            while (n < 17) n += queue_run();
         end
         // Let the block drain completely before offering the rest of the phase.
         wait_idle();
         while (n < 17) n += queue_run();
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0 && extrema_due.size() == 0)
         $display("extremum_finder_parabolic_tb: PASS");
      else
         $display("extremum_finder_parabolic_tb: FAIL");
      $finish;
   end

endmodule
